### hdl/graph_adjacency_store_macros.svh
// ----------------------------------------------------------------------------
// graph_adjacency_store assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GRAPH_ADJACENCY_STORE_MACROS_SVH
`define GRAPH_ADJACENCY_STORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define GAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define GAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/gas_pkg.sv
// ----------------------------------------------------------------------------
// gas_pkg
// Types and constants shared by the adjacency store modules.
// ----------------------------------------------------------------------------
package gas_pkg;

  localparam int VTX_LIMIT = 16;  // vertex fields are 4 bits wide
  localparam int VTX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int KIND_W    = 3;

  typedef enum logic [KIND_W-1:0] {
    K_ADD    = 3'd0,
    K_REMOVE = 3'd1,
    K_QUERY  = 3'd2,
    K_DEGREE = 3'd3,
    K_LIST   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MIRROR,
    S_SCAN,
    S_FLUSH
  } state_t;

  // single-bit write into the matrix
  typedef struct packed {
    logic             en;
    logic [VTX_W-1:0] row;
    logic [VTX_W-1:0] col;
    logic             val;
  } mat_wr_t;

  typedef struct packed {
    logic             valid;
    logic             edge_present;
    logic [CNT_W-1:0] degree;
    logic [VTX_W-1:0] odd_vertex;
    logic             odd_found;
    logic [CNT_W-1:0] odd_count;
    logic             last;
    logic             error;
  } result_t;

endpackage

### hdl/gas_matrix.sv
// ----------------------------------------------------------------------------
// gas_matrix
// Adjacency bit rows, cleared at reset; one row read, one bit written a cycle.
// ----------------------------------------------------------------------------
module gas_matrix #(
  parameter int NV = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [$clog2(NV)-1:0] rd_addr,
  output logic [NV-1:0]        rd_row,
  input  gas_pkg::mat_wr_t     wr
);
  import gas_pkg::*;

  localparam int IW = $clog2(NV);

  logic [NV-1:0] rows [NV];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '{default: '0};
    end else if (wr.en) begin
      rows[wr.row[IW-1:0]][wr.col[IW-1:0]] <= wr.val;
    end
  end

  assign rd_row = rows[rd_addr];

endmodule

### hdl/gas_popcnt.sv
// ----------------------------------------------------------------------------
// gas_popcnt
// Shared row unit: counts set bits of a row below the active vertex count.
// ----------------------------------------------------------------------------
module gas_popcnt (
  input  logic [gas_pkg::VTX_LIMIT-1:0] row,
  input  logic [gas_pkg::CNT_W-1:0]     n,
  output logic [gas_pkg::CNT_W-1:0]     count
);
  import gas_pkg::*;

  localparam int NIB = VTX_LIMIT / 4;

  logic [VTX_LIMIT-1:0] masked;
  logic [2:0]           nib [NIB];

  always_comb begin
    for (int i = 0; i < VTX_LIMIT; i++) begin
      masked[i] = row[i] & (CNT_W'(i) < n);
    end
    for (int j = 0; j < NIB; j++) begin
      nib[j] = 3'(masked[4*j]) + 3'(masked[4*j+1]) + 3'(masked[4*j+2])
             + 3'(masked[4*j+3]);
    end
    count = '0;
    for (int j = 0; j < NIB; j++) begin
      count = count + CNT_W'(nib[j]);
    end
  end

endmodule

### hdl/graph_adjacency_store.sv
// ----------------------------------------------------------------------------
// graph_adjacency_store
// Undirected graph kept as a symmetric bit matrix with edge, degree and odd-vertex listing ops.
// ----------------------------------------------------------------------------
// Usage:
//   Command in: kind, vertex_a, vertex_b, taken when start is high and busy
//   is low. Config: cfg_we/cfg_data set vertex_count (reset 16); write only
//   while idle.
//   Results: one word per cycle marked by valid, with last on the final word
//   of a command. The receiver cannot stall; every word is taken as shown.
//   Sequence, from the accepted command to the valid word:
//     add/remove edge   busy while exec writes (a,b) and mirror writes (b,a); word from mirror
//     query/degree/error word registered from the exec state
//     odd listing       exec, then a scan over the n active vertices; rows are
//                       scanned one per cycle through the shared bit counter,
//                       words trail the scan by one odd vertex, the last word
//                       is registered from the flush state after the scan
//   A new command may be accepted in the cycle its predecessor's last word
//   is shown. Reset clears all edges and the sequencer.
// ----------------------------------------------------------------------------
`include "graph_adjacency_store_macros.svh"

module graph_adjacency_store #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gas_pkg::KIND_W-1:0] kind,
  input  logic [gas_pkg::VTX_W-1:0]  vertex_a,
  input  logic [gas_pkg::VTX_W-1:0]  vertex_b,
  output logic                       busy,
  input  logic                       cfg_we,
  input  logic [gas_pkg::CNT_W-1:0]  cfg_data,
  output logic                       valid,
  output logic                       edge_present,
  output logic [gas_pkg::CNT_W-1:0]  degree,
  output logic [gas_pkg::VTX_W-1:0]  odd_vertex,
  output logic                       odd_found,
  output logic [gas_pkg::CNT_W-1:0]  odd_count,
  output logic                       last,
  output logic                       error
);
  import gas_pkg::*;

  localparam int NV = (MAX_VERTICES < VTX_LIMIT) ? MAX_VERTICES : VTX_LIMIT;
  localparam int IW = $clog2(NV);

  state_t           state, state_next;
  logic [KIND_W-1:0] kind_r;
  logic [VTX_W-1:0] a_r, b_r;
  logic [CNT_W-1:0] vertex_count;
  logic [VTX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [VTX_W-1:0] pend, pend_next;
  result_t          res, res_next;
  mat_wr_t          wr;

  logic [CNT_W-1:0] n_eff;
  logic [IW-1:0]    rd_addr;
  logic [NV-1:0]    rd_row;
  logic [CNT_W-1:0] pop;
  logic             cmd_err, scan_last;

  assign n_eff = (vertex_count > CNT_W'(NV)) ? CNT_W'(NV) : vertex_count;
  assign rd_addr = (state == S_SCAN) ? idx[IW-1:0] : a_r[IW-1:0];
  assign cmd_err = (kind_r > K_LIST) || ({1'b0, a_r} >= n_eff)
                || ((kind_r <= K_QUERY) && ({1'b0, b_r} >= n_eff));
  assign scan_last = ({1'b0, idx} == (n_eff - CNT_W'(1)));

  gas_matrix #(.NV(NV)) u_matrix (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr      (wr)
  );

  gas_popcnt u_popcnt (
    .row   (VTX_LIMIT'(rd_row)),
    .n     (n_eff),
    .count (pop)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= CNT_W'(VTX_LIMIT);
      res          <= '0;
    end else begin
      state <= state_next;
      res   <= res_next;
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r <= kind;
      a_r    <= vertex_a;
      b_r    <= vertex_b;
    end
    idx  <= idx_next;
    cnt  <= cnt_next;
    pend <= pend_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (kind_r == K_LIST) begin
          state_next = (n_eff != '0) ? S_SCAN : S_IDLE;
        end else if (!cmd_err && (kind_r == K_ADD || kind_r == K_REMOVE)) begin
          state_next = S_MIRROR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MIRROR: state_next = S_IDLE;
      S_SCAN: begin
        if (scan_last) state_next = S_FLUSH;
      end
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control and result words
  always_comb begin
    res_next  = '0;
    wr        = '0;
    idx_next  = idx;
    cnt_next  = cnt;
    pend_next = pend;
    case (state)
      S_EXEC: begin
        if (kind_r == K_LIST) begin
          idx_next = '0;
          cnt_next = '0;
          if (n_eff == '0) begin
            res_next.valid = 1'b1;
            res_next.last  = 1'b1;
          end
        end else if (cmd_err) begin
          res_next.valid = 1'b1;
          res_next.last  = 1'b1;
          res_next.error = 1'b1;
        end else begin
          case (kind_r)
            K_ADD:    wr = '{en: 1'b1, row: a_r, col: b_r, val: 1'b1};
            K_REMOVE: wr = '{en: 1'b1, row: a_r, col: b_r, val: 1'b0};
            K_QUERY: begin
              res_next.valid        = 1'b1;
              res_next.last         = 1'b1;
              res_next.edge_present = rd_row[b_r[IW-1:0]];
            end
            K_DEGREE: begin
              res_next.valid  = 1'b1;
              res_next.last   = 1'b1;
              res_next.degree = pop;
            end
            default: res_next = '0;
          endcase
        end
      end
      S_MIRROR: begin
        wr = '{en: 1'b1, row: b_r, col: a_r, val: (kind_r == K_ADD)};
        res_next.valid = 1'b1;
        res_next.last  = 1'b1;
      end
      S_SCAN: begin
        // an odd row releases the previously held vertex, not yet known last
        if (pop[0]) begin
          if (cnt != '0) begin
            res_next.valid      = 1'b1;
            res_next.odd_vertex = pend;
            res_next.odd_found  = 1'b1;
            res_next.odd_count  = cnt;
          end
          pend_next = idx;
          cnt_next  = cnt + CNT_W'(1);
        end
        idx_next = idx + VTX_W'(1);
      end
      S_FLUSH: begin
        res_next.valid = 1'b1;
        res_next.last  = 1'b1;
        if (cnt != '0) begin
          res_next.odd_vertex = pend;
          res_next.odd_found  = 1'b1;
          res_next.odd_count  = cnt;
        end
      end
      default: res_next = '0;
    endcase
  end

  assign busy         = (state != S_IDLE);
  assign valid        = res.valid;
  assign edge_present = res.edge_present;
  assign degree       = res.degree;
  assign odd_vertex   = res.odd_vertex;
  assign odd_found    = res.odd_found;
  assign odd_count    = res.odd_count;
  assign last         = res.last;
  assign error        = res.error;

  `GAS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `GAS_ASSERT_SAME(a_err_last, valid && error, last, "error word without last")
  `GAS_ASSERT_SAME(a_odd_cnt, valid && odd_found, odd_count != '0, "odd word with zero count")
  `GAS_ASSERT_SAME(a_wr_busy, wr.en, busy, "matrix write while idle")

endmodule
